### src/assert_macros.svh
// Assertion macros shared by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rcs_pkg.sv
// Types and constants of the coefficient rejection sampler.
package rcs_pkg;

  // Field modulus of the lattice scheme
  localparam logic [23:0] MODULUS = 24'd8380417;

  // Sample mode codes
  localparam logic [1:0] MODE_UNIFORM = 2'd0;
  localparam logic [1:0] MODE_ETA     = 2'd1;
  localparam logic [1:0] MODE_GAMMA   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_ETA   = 2'd1;
  localparam logic [1:0] REG_GAMMA = 2'd2;

  localparam int unsigned CFG_DW = 20;

  // Reset values and the bounds derived from them
  localparam logic [2:0]  ETA_RST    = 3'd5;
  localparam logic [19:0] GAMMA_RST  = 20'd523776;
  localparam logic [23:0] BASE_E_RST = 24'(MODULUS + 24'(ETA_RST));
  localparam logic [20:0] LIM_G_RST  = 21'({1'b0, GAMMA_RST, 1'b0} - 22'd2);
  localparam logic [23:0] BASE_G_RST = 24'(MODULUS + 24'(GAMMA_RST) - 24'd1);

  // Up to two accepted coefficients from one byte or completed byte group, in output order
  typedef struct packed {
    logic [23:0] val0;
    logic [23:0] val1;
    logic [7:0]  idx;
    logic        two;
    logic        done0;
    logic        done1;
  } rcs_entry_t;

endpackage

### src/rcs_if.sv
// Valid/ready channels for random bytes and for sampled coefficients.
interface rcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rand_byte;
  logic       begin_poly;

  modport source (output valid, output rand_byte, output begin_poly, input ready);
  modport sink   (input valid, input rand_byte, input begin_poly, output ready);
endinterface

interface rcs_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] coeff_value;
  logic [7:0]  coeff_index;
  logic        poly_done;

  modport source (output valid, output coeff_value, output coeff_index,
                  output poly_done, input ready);
  modport sink   (input valid, input coeff_value, input coeff_index,
                  input poly_done, output ready);
endinterface

### src/rcs_front.sv
// Front end: configuration, byte grouping, bound checks and coefficient numbering.
`include "assert_macros.svh"

module rcs_front import rcs_pkg::*; #(
  parameter int unsigned COEFFS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rcs_in_if.sink            in_if,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output rcs_entry_t        entry_o
);

  localparam int unsigned CW = $clog2(COEFFS + 1);

  logic [1:0]    mode_q;
  logic [2:0]    eta_q;
  logic [23:0]   base_e_q;
  logic [20:0]   lim_g_q;
  logic [23:0]   base_g_q;
  logic          g_nz_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   held_q, held_d;
  logic [2:0]    phase_q, phase_d;

  logic          accept;
  logic [CW-1:0] cnt_b, cnt1;
  logic [31:0]   held_b;
  logic [2:0]    phase_b;
  logic          full;
  logic          keep0, keep1, e0, e1;
  logic [23:0]   v0, v1;
  logic [22:0]   t_u;
  logic [3:0]    t_e0, t_e1;
  logic [19:0]   t_g0, t_g1;
  logic [3:0]    lim_e;
  logic [19:0]   g_new;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign g_new       = cfg_data_i[19:0];

  // Apply the start-of-polynomial clear ahead of this byte
  assign cnt_b   = in_if.begin_poly ? '0 : cnt_q;
  assign held_b  = in_if.begin_poly ? '0 : held_q;
  assign phase_b = in_if.begin_poly ? '0 : phase_q;
  assign full    = cnt_b >= CW'(COEFFS);
  assign lim_e   = {eta_q, 1'b0};

  // Group bytes and check candidates against the mode's bound
  always_comb begin
    held_d  = held_b;
    phase_d = phase_b;
    keep0   = 1'b0;
    keep1   = 1'b0;
    v0      = '0;
    v1      = '0;
    t_u     = {in_if.rand_byte[6:0], held_b[15:0]};
    t_g0    = held_b[19:0];
    t_g1    = {in_if.rand_byte, held_b[31:20]};
    if (eta_q <= 3'd3) begin
      t_e0 = {1'b0, in_if.rand_byte[2:0]};
      t_e1 = {1'b0, in_if.rand_byte[7:5]};
    end else begin
      t_e0 = in_if.rand_byte[3:0];
      t_e1 = in_if.rand_byte[7:4];
    end
    if (!full) begin
      case (mode_q)
        MODE_UNIFORM: begin
          if (phase_b < 3'd2) begin
            held_d  = held_b | ({24'd0, in_if.rand_byte} << {phase_b[1:0], 3'b000});
            phase_d = phase_b + 3'd1;
          end else begin
            held_d  = '0;
            phase_d = '0;
            keep0   = t_u < MODULUS[22:0];
            v0      = {1'b0, t_u};
          end
        end
        MODE_ETA: begin
          keep0 = t_e0 <= lim_e;
          keep1 = t_e1 <= lim_e;
          v0    = base_e_q - {20'd0, t_e0};
          v1    = base_e_q - {20'd0, t_e1};
        end
        MODE_GAMMA: begin
          if (phase_b < 3'd4) begin
            held_d  = held_b | ({24'd0, in_if.rand_byte} << {phase_b[1:0], 3'b000});
            phase_d = phase_b + 3'd1;
          end else begin
            held_d  = '0;
            phase_d = '0;
            keep0   = g_nz_q && ({1'b0, t_g0} <= lim_g_q);
            keep1   = g_nz_q && ({1'b0, t_g1} <= lim_g_q);
            v0      = base_g_q - {4'd0, t_g0};
            v1      = base_g_q - {4'd0, t_g1};
          end
        end
        default: ;
      endcase
    end
  end

  // Number the kept coefficients and stop at the polynomial length
  assign e0    = keep0 && !full;
  assign cnt1  = cnt_b + CW'(e0);
  assign e1    = keep1 && (cnt1 < CW'(COEFFS));
  assign cnt_d = cnt1 + CW'(e1);

  assign push_o        = accept && (e0 || e1);
  assign entry_o.val0  = e0 ? v0 : v1;
  assign entry_o.val1  = v1;
  assign entry_o.idx   = 8'(cnt_b);
  assign entry_o.two   = e0 && e1;
  assign entry_o.done0 = ({1'b0, cnt_b} + (CW+1)'(1)) == (CW+1)'(COEFFS);
  assign entry_o.done1 = ({1'b0, cnt_b} + (CW+1)'(2)) == (CW+1)'(COEFFS);

  // Hold configuration and the bounds derived from it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_UNIFORM;
      eta_q    <= ETA_RST;
      base_e_q <= BASE_E_RST;
      lim_g_q  <= LIM_G_RST;
      base_g_q <= BASE_G_RST;
      g_nz_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE: mode_q <= cfg_data_i[1:0];
        REG_ETA: begin
          eta_q    <= cfg_data_i[2:0];
          base_e_q <= MODULUS + {21'd0, cfg_data_i[2:0]};
        end
        REG_GAMMA: begin
          lim_g_q  <= {g_new, 1'b0} - 21'd2;
          base_g_q <= MODULUS + {4'd0, g_new} - 24'd1;
          g_nz_q   <= |g_new;
        end
        default: ;
      endcase
    end
  end

  // Advance count and byte grouping; a mode write drops the partial group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      held_q  <= '0;
      phase_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == REG_MODE)) begin
      held_q  <= '0;
      phase_q <= '0;
    end else if (accept) begin
      cnt_q   <= cnt_d;
      held_q  <= held_d;
      phase_q <= phase_d;
    end
  end

  `RCS_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= CW'(COEFFS), "coefficient count past length")
  `RCS_ASSERT_IMP(a_phase_max, 1'b1, phase_q <= 3'd4, "byte group phase out of range")

endmodule

### src/rcs_queue.sv
// Short queue of coefficient entries between front and back end.
`include "assert_macros.svh"

module rcs_queue import rcs_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rcs_entry_t entry_i,
  input  logic       pop_i,
  output rcs_entry_t head_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  rcs_entry_t    slots_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] num_q, num_d;

  assign full_o  = num_q == NW'(DEPTH);
  assign empty_o = num_q == '0;
  assign head_o  = slots_q[rd_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      num_d = num_q + NW'(1);
    end else if (pop_i && !push_i) begin
      num_d = num_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  `RCS_ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into full queue")
  `RCS_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "pop from empty queue")
  `RCS_ASSERT_NXT(a_push_lands, push_i && !pop_i, !empty_o, "pushed entry lost")

endmodule

### src/rcs_back.sv
// Back end: splits queue entries into single coefficient beats behind an output register.
`include "assert_macros.svh"

module rcs_back import rcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rcs_entry_t head_i,
  input  logic       empty_i,
  output logic       pop_o,
  rcs_out_if.source  out_if
);

  logic        sel_q, sel_d;
  logic        vld_q, vld_d;
  logic [23:0] val_q, val_d;
  logic [7:0]  idx_q, idx_d;
  logic        done_q, done_d;
  logic        load;

  assign load = !empty_i && (!vld_q || out_if.ready);

  // Pick the next coefficient of the head entry; drop the entry after its last one
  always_comb begin
    sel_d  = sel_q;
    pop_o  = 1'b0;
    val_d  = val_q;
    idx_d  = idx_q;
    done_d = done_q;
    vld_d  = vld_q && !out_if.ready;
    if (load) begin
      vld_d = 1'b1;
      if (!sel_q) begin
        val_d  = head_i.val0;
        idx_d  = head_i.idx;
        done_d = head_i.done0;
        pop_o  = !head_i.two;
        sel_d  = head_i.two;
      end else begin
        val_d  = head_i.val1;
        idx_d  = head_i.idx + 8'd1;
        done_d = head_i.done1;
        pop_o  = 1'b1;
        sel_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    idx_q  <= idx_d;
    done_q <= done_d;
  end

  assign out_if.valid       = vld_q;
  assign out_if.coeff_value = val_q;
  assign out_if.coeff_index = idx_q;
  assign out_if.poly_done   = done_q;

  `RCS_ASSERT_IMP(a_sel_two, sel_q, !empty_i && head_i.two, "second slot without pair entry")

endmodule

### src/lattice_coefficient_rejection_sampler_top.sv
// Top level of the coefficient rejection sampler.
//
//  channel  dir  beat                                   handshake
//  in_if    in   rand_byte[8], begin_poly[1]            valid/ready
//  out_if   out  coeff_value[24], coeff_index[8], done  valid/ready
//  cfg      in   cfg_idx_i[2], cfg_data_i[20]           cfg_we_i, no stall
//
// One byte is taken every cycle while the entry queue has room; a coefficient
// passes through an entry queue slot and then the output register before it leaves.
// The output register sends one coefficient per cycle while out_if is ready, so in eta
// mode, with up to two coefficients per byte, the output can fall behind the byte input.
// Reset is asynchronous and sets the documented register values; no clearing pass.
// A stall on out_if fills the queue, then drops in_if.ready.
module lattice_coefficient_rejection_sampler_top import rcs_pkg::*; #(
  parameter int unsigned COEFFS      = 256,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rcs_in_if.sink            in_if,
  rcs_out_if.source         out_if,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  rcs_entry_t entry;
  rcs_entry_t head;

  rcs_front #(
    .COEFFS (COEFFS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  rcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rcs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule
